@@ hw/rtl/record_insertion_sorter_assert.svh @@
// Assertion macros for the record sorter.
`ifndef RECORD_INSERTION_SORTER_ASSERT_SVH
`define RECORD_INSERTION_SORTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RIS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RIS_ASSERT(lbl, prop, msg)
`define RIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/ris_pkg.sv @@
package ris_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 24;
    localparam int AMT_W  = 20;
    localparam int REC_W  = KEY_W + 3 * AMT_W;
    localparam int DATA_W = ((REC_W + 7) / 8) * 8;

    // first member sits in the high bits, so key ends up lowest
    typedef struct packed {
        logic [AMT_W-1:0] amount_floor;
        logic [AMT_W-1:0] amount_cap;
        logic [AMT_W-1:0] amount_now;
        logic [KEY_W-1:0] record_key;
    } rec_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_HOLD,
        ST_CMP,
        ST_PLACE,
        ST_OFETCH,
        ST_EMIT
    } state_t;

endpackage

@@ hw/rtl/record_insertion_sorter.sv @@
// Load: one item per cycle, tready high only while loading.
// Sort: record j is compared downward; each record it moves past shifts up one slot
// (one read/compare/write step of the shared key comparator per cycle).
// Output: ST_OFETCH primes the store read, then one item per cycle while m_tready is high.
// The first result follows the final item once every record has been sorted.
// Reset clears control and the fill count; the record store is not cleared.
`include "record_insertion_sorter_assert.svh"

module record_insertion_sorter
    import ris_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // record_key[23:0], amount_now[43:24], amount_cap[63:44], amount_floor[83:64]
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // sorted_key[23:0], sorted_now[43:24], sorted_cap[63:44], sorted_floor[83:64]
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    rec_t             rec_reg, rec_next;

    rec_t             mem [DEPTH];
    rec_t             rd_q;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    rec_t             mem_wd;

    rec_t             in_rec;
    logic             not_full;
    logic [CNT_W-1:0] fill_after;
    logic             shift_up;
    logic             last_pos;
    logic             sort_done;

    assign in_rec     = rec_t'(s_tdata[REC_W-1:0]);
    assign not_full   = (fill_reg < CNT_W'(DEPTH));
    assign fill_after = fill_reg + CNT_W'(not_full);
    assign shift_up   = (rd_q.record_key > rec_reg.record_key);
    assign last_pos   = (j_reg == fill_reg - CNT_W'(1));
    assign sort_done  = (j_reg + CNT_W'(1) == fill_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            j_reg     <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            j_reg     <= j_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = (fill_after > CNT_W'(1)) ? ST_FETCH : ST_OFETCH;
                end
            end
            ST_FETCH:  state_next = ST_HOLD;
            ST_HOLD:   state_next = ST_CMP;
            ST_CMP:
            begin
                if (shift_up)
                begin
                    state_next = (pos_reg == IDX_W'(1)) ? ST_PLACE : ST_CMP;
                end
                else
                begin
                    state_next = sort_done ? ST_OFETCH : ST_FETCH;
                end
            end
            ST_PLACE:  state_next = sort_done ? ST_OFETCH : ST_FETCH;
            ST_OFETCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (m_tready && last_pos)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = rec_reg;
        rd_en     = 1'b0;
        rd_addr   = '0;
        fill_next = fill_reg;
        j_next    = j_reg;
        pos_next  = pos_reg;
        rec_next  = rec_reg;
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (not_full)
                    begin
                        mem_we    = 1'b1;
                        mem_wa    = fill_reg[IDX_W-1:0];
                        mem_wd    = in_rec;
                        fill_next = fill_after;
                    end
                    if (s_tlast)
                    begin
                        j_next = CNT_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg[IDX_W-1:0];
            end
            ST_HOLD:
            begin
                rec_next = rd_q;
                rd_en    = 1'b1;
                rd_addr  = j_reg[IDX_W-1:0] - IDX_W'(1);
                pos_next = j_reg[IDX_W-1:0];
            end
            ST_CMP:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                if (shift_up)
                begin
                    // move the bigger neighbor up, look one further down
                    mem_wd   = rd_q;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg != IDX_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    mem_wd = rec_reg;
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_PLACE:
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = rec_reg;
                j_next = j_reg + CNT_W'(1);
            end
            ST_OFETCH:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
                j_next  = '0;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (last_pos)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = j_reg[IDX_W-1:0] + IDX_W'(1);
                        j_next  = j_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                fill_next = '0;
            end
        endcase
    end

    assign m_tdata = {{(DATA_W - REC_W){1'b0}}, rd_q};
    assign m_tlast = last_pos;

    `RIS_ASSERT_ALWAYS(a_sides_exclusive, !(s_tready && m_tvalid), "load and emit overlap")
    `RIS_ASSERT(a_fill_bound, fill_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `RIS_ASSERT(a_cmp_pos, (state_reg == ST_CMP) |-> (pos_reg != '0), "compare at slot zero")
    `RIS_ASSERT(a_run_end_empties, (m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_reg == '0), "set not emptied after run end")

endmodule
